### sv/raidz_column_map_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RAID-Z column map
// Helpers for concurrent checks, used by the divider.
// ---------------------------------------------------------------------------
`ifndef RAIDZ_COLUMN_MAP_ASSERT_SVH
`define RAIDZ_COLUMN_MAP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rcm assertion failed");

// A condition that must hold in the cycle after a trigger, outside reset.
`define RCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcm assertion failed");

`endif

### sv/rcm_pkg.sv
// ---------------------------------------------------------------------------
// RAID-Z column map package
// Field widths, register indexes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package rcm_pkg;

    localparam int OFF_W     = 63;
    localparam int SIZE_W    = 25;
    localparam int SH_W      = 5;
    localparam int COL_W     = 5;
    localparam int PAR_W     = 2;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int IN_W      = OFF_W + SIZE_W;
    localparam int OUT_W     = 2 * IDX_W + OFF_W + SIZE_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 2'd2;

    localparam logic [SH_W-1:0]  RST_SECTOR_SHIFT = 5'd12;
    localparam logic [COL_W-1:0] RST_COLUMN_COUNT = 5'd4;
    localparam logic [PAR_W-1:0] RST_PARITY_COUNT = 2'd1;

    // Offset bit that turns on the single-parity column swap.
    localparam int ROTATE_BIT = 20;

    // Divider: 64-bit left-aligned dividend, two quotient bits per cycle.
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_OFF  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SIZE = 6'd13;

    typedef struct packed {
        logic capture;
        logic start_b;
        logic take_b;
        logic start_s;
        logic take_s;
        logic prep;
        logic emit;
    } t_rcm_cmd;

    typedef struct packed {
        logic cfg_ok;
        logic div_done;
        logic empty;
        logic last;
        logic out_free;
    } t_rcm_sts;

endpackage

### sv/raidz_column_map.sv
// ---------------------------------------------------------------------------
// RAID-Z column map
// Splits a block request into one word per data column of a RAID-Z stripe.
//
// The slave stream takes one request word (byte offset and byte size); the
// master stream returns one word per data column in column order, with tlast
// on the final column. A request of less than one sector, or one made under
// an invalid column/parity setting, returns no word. The configuration
// channel writes sector shift, column count and parity count and should
// only be used while no request is in flight.
// After a request is taken, the controller steps through a check, the
// offset division in the shared divider (two quotient bits per cycle), an
// offset setup step, the sector division and a prep step before the first
// emit. Words then follow one per cycle while the receiver takes them, and
// the next request is taken once the last word sits in the output register.
// Reset loads shift 12, four columns and single parity, empties the output
// register and keeps both ready signals low until the first cycle after
// reset. When the receiver stalls, the current word holds, emission pauses
// and the slave stream is not ready.
// ---------------------------------------------------------------------------
module raidz_column_map #(
    parameter int MAX_COLUMNS = 16,
    parameter int LABEL_BYTES = 4194304
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rcm_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // block_offset [62:0], block_size [87:63]
    input  logic [rcm_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // column_index [3:0], device_index [7:4], device_offset [70:8],
    // column_bytes [95:71]
    output logic [rcm_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tlast
);
    import rcm_pkg::*;

    logic [SH_W-1:0]  r_sector_shift;
    logic [COL_W-1:0] r_column_count;
    logic [PAR_W-1:0] r_parity_count;
    logic             r_cfg_ready;

    t_rcm_cmd w_cmd;
    t_rcm_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_shift <= RST_SECTOR_SHIFT;
            r_column_count <= RST_COLUMN_COUNT;
            r_parity_count <= RST_PARITY_COUNT;
            r_cfg_ready    <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SECTOR_SHIFT: r_sector_shift <= i_cfg_data;
                    CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                    CFG_PARITY_COUNT: r_parity_count <= i_cfg_data[PAR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    rcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rcm_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .LABEL_BYTES (LABEL_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sector_shift (r_sector_shift),
        .i_column_count (r_column_count),
        .i_parity_count (r_parity_count),
        .i_in_data      (s_axis_tdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

### sv/rcm_div.sv
// ---------------------------------------------------------------------------
// RAID-Z column map divider
// Shared restoring divider by a small divisor, two quotient bits per cycle.
// ---------------------------------------------------------------------------
`include "raidz_column_map_assert.svh"

module rcm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rcm_pkg::DIV_W-1:0]     i_dividend,
    input  logic [rcm_pkg::COL_W-1:0]     i_divisor,
    input  logic [rcm_pkg::DIV_CNT_W-1:0] i_steps,
    output logic                         o_done,
    output logic [rcm_pkg::DIV_W-1:0]     o_quot,
    output logic [rcm_pkg::COL_W-1:0]     o_rem
);
    import rcm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [DIV_W-1:0]     r_quo;
    logic [COL_W-1:0]     r_rem;
    logic [COL_W-1:0]     r_div;

    logic [DIV_W-1:0]     n_num;
    logic [DIV_W-1:0]     n_quo;
    logic [COL_W-1:0]     n_rem;
    logic [COL_W:0]       w_trial;

    // The remainder stays below the divisor, so each trial value is below
    // twice the divisor and one subtract settles the bit.
    always_comb begin
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        w_trial = '0;
        for (int k = 0; k < 2; k++) begin
            w_trial = {n_rem, n_num[DIV_W-1]};
            n_num   = {n_num[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = COL_W'(w_trial - {1'b0, r_div});
                n_quo = {n_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[COL_W-1:0];
                n_quo = {n_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    `RCM_ASSERT(a_rem_below_div, i_clk, i_rst_n, !(r_busy && r_div != '0) || (r_rem < r_div))
    `RCM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `RCM_ASSERT(a_done_idle, i_clk, i_rst_n, !r_done || !r_busy)

endmodule

### sv/rcm_dp.sv
// ---------------------------------------------------------------------------
// RAID-Z column map datapath
// Sector conversion, the two divisions, column bookkeeping and output word.
// ---------------------------------------------------------------------------
module rcm_dp #(
    parameter int MAX_COLUMNS = 16,
    parameter int LABEL_BYTES = 4194304
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcm_pkg::t_rcm_cmd            i_cmd,
    output rcm_pkg::t_rcm_sts            o_sts,
    input  logic [rcm_pkg::SH_W-1:0]     i_sector_shift,
    input  logic [rcm_pkg::COL_W-1:0]    i_column_count,
    input  logic [rcm_pkg::PAR_W-1:0]    i_parity_count,
    input  logic [rcm_pkg::IN_W-1:0]     i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rcm_pkg::OUT_W-1:0]    o_out_data,
    output logic                         o_out_last
);
    import rcm_pkg::*;

    logic [OFF_W-1:0]  w_off;
    logic [SIZE_W-1:0] w_size;
    logic              w_cfg_ok;

    logic [OFF_W-1:0]  r_b;
    logic [SIZE_W-1:0] r_s;
    logic              r_rot;
    logic              r_cfg_ok;
    logic [OFF_W-1:0]  r_unit;
    logic [COL_W-1:0]  r_first;
    logic [OFF_W-1:0]  r_row;
    logic [OFF_W-1:0]  r_off0;
    logic [OFF_W-1:0]  r_off1;
    logic [SIZE_W-1:0] r_q;
    logic [COL_W-1:0]  r_r;
    logic [CNT_W-1:0]  r_bc;
    logic [CNT_W-1:0]  r_acols;
    logic [SIZE_W-1:0] r_bq;
    logic [SIZE_W-1:0] r_bq1;
    logic [CNT_W-1:0]  r_c;

    logic              r_ov;
    logic [OUT_W-1:0]  r_od;
    logic              r_ol;

    logic              w_div_start;
    logic [DIV_W-1:0]  w_dividend;
    logic [COL_W-1:0]  w_divisor;
    logic [DIV_CNT_W-1:0] w_steps;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quot;
    logic [COL_W-1:0]  w_rem;

    logic [CNT_W-1:0]  w_bc;
    logic [CNT_W-1:0]  w_src;
    logic [CNT_W:0]    w_dev;
    logic              w_wrap;
    logic [CNT_W:0]    w_dev_fix;
    logic              w_last;

    assign w_off  = i_in_data[OFF_W-1:0];
    assign w_size = i_in_data[IN_W-1:OFF_W];

    assign w_cfg_ok = (i_column_count >= COL_W'(2))
                   && (int'(i_column_count) <= MAX_COLUMNS)
                   && (i_parity_count != '0)
                   && ({3'b0, i_parity_count} < i_column_count);

    // The offset goes through the divider by the column count, the sector
    // count through the divider by the number of data columns.
    assign w_div_start = i_cmd.start_b || i_cmd.start_s;
    assign w_dividend  = i_cmd.start_b ? {1'b0, r_b}
                                       : {1'b0, r_s, {(DIV_W - 1 - SIZE_W){1'b0}}};
    assign w_divisor   = i_cmd.start_b ? i_column_count
                                       : COL_W'(i_column_count - {3'b0, i_parity_count});
    assign w_steps     = i_cmd.start_b ? DIV_STEPS_OFF : DIV_STEPS_SIZE;

    rcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_bc = (r_r == '0) ? '0 : CNT_W'(r_r) + CNT_W'(i_parity_count);

    // With the single-parity swap, the first data column takes column 0's place.
    assign w_src     = (r_rot && r_c == CNT_W'(1)) ? '0 : r_c;
    assign w_dev     = (CNT_W + 1)'(r_first) + (CNT_W + 1)'(w_src);
    assign w_wrap    = w_dev >= (CNT_W + 1)'(i_column_count);
    assign w_dev_fix = w_wrap ? w_dev - (CNT_W + 1)'(i_column_count) : w_dev;
    assign w_last    = (r_c + 1'b1) == r_acols;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_b      <= w_off >> i_sector_shift;
            r_s      <= w_size >> i_sector_shift;
            r_rot    <= w_off[ROTATE_BIT] && (i_parity_count == PAR_W'(1));
            r_cfg_ok <= w_cfg_ok;
            r_unit   <= OFF_W'(LABEL_BYTES) + (OFF_W'(1) << i_sector_shift);
        end
        if (i_cmd.take_b) begin
            r_first <= w_rem;
            r_row   <= OFF_W'(w_quot << i_sector_shift);
        end
        if (i_cmd.start_s) begin
            r_off0 <= r_row + OFF_W'(LABEL_BYTES);
            r_off1 <= r_row + r_unit;
        end
        if (i_cmd.take_s) begin
            r_q <= w_quot[SIZE_W-1:0];
            r_r <= w_rem;
        end
        if (i_cmd.prep) begin
            r_bc    <= w_bc;
            r_acols <= (r_q == '0) ? w_bc : CNT_W'(i_column_count);
            r_bq    <= r_q << i_sector_shift;
            r_bq1   <= SIZE_W'(r_q + 1'b1) << i_sector_shift;
            r_c     <= CNT_W'(i_parity_count);
        end else if (i_cmd.emit) begin
            r_c <= r_c + 1'b1;
        end
    end

    // Output register: holds one column word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_od <= {(r_c < r_bc) ? r_bq1 : r_bq,
                     w_wrap ? r_off1 : r_off0,
                     w_dev_fix[IDX_W-1:0],
                     r_c[IDX_W-1:0]};
            r_ol <= w_last;
        end
    end

    assign o_sts.cfg_ok   = r_cfg_ok;
    assign o_sts.div_done = w_div_done;
    assign o_sts.empty    = r_acols <= CNT_W'(i_parity_count);
    assign o_sts.last     = w_last;
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_out_last  = r_ol;

endmodule

### sv/rcm_ctrl.sv
// ---------------------------------------------------------------------------
// RAID-Z column map controller
// Sequences capture, the two divisions, setup and the column emission.
// ---------------------------------------------------------------------------
module rcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rcm_pkg::t_rcm_sts i_sts,
    output rcm_pkg::t_rcm_cmd o_cmd
);
    import rcm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_B,
        ST_OFFS,
        ST_DIV_S,
        ST_PREP,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = i_in_valid && r_in_ready;
        o_cmd.start_b = (r_state == ST_CHECK) && i_sts.cfg_ok;
        o_cmd.take_b  = (r_state == ST_DIV_B) && i_sts.div_done;
        o_cmd.start_s = (r_state == ST_OFFS);
        o_cmd.take_s  = (r_state == ST_DIV_S) && i_sts.div_done;
        o_cmd.prep    = (r_state == ST_PREP);
        o_cmd.emit    = (r_state == ST_EMIT) && !i_sts.empty && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state    <= ST_CHECK;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (i_sts.cfg_ok) begin
                        r_state <= ST_DIV_B;
                    end else begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                ST_DIV_B: begin
                    if (i_sts.div_done) begin
                        r_state <= ST_OFFS;
                    end
                end
                ST_OFFS: begin
                    r_state <= ST_DIV_S;
                end
                ST_DIV_S: begin
                    if (i_sts.div_done) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_sts.empty || (o_cmd.emit && i_sts.last)) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_ready;

endmodule
